// ----- rtl/core/lsp_pkg.sv -----
package lsp_pkg;

  localparam int NUM_CH = 8;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ALL_BLACK    = 3'd1;
  localparam logic [2:0] ST_DISCONT      = 3'd2;
  localparam logic [2:0] ST_LOST_LEFT    = 3'd3;
  localparam logic [2:0] ST_LOST_RIGHT   = 3'd4;
  localparam logic [2:0] ST_LOST_UNKNOWN = 3'd5;

  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_LEFT    = 2'd1;
  localparam logic [1:0] DIR_RIGHT   = 2'd2;

  localparam logic [3:0] THRESH_RESET = 4'd6;
  localparam logic [7:0] ALL_WHITE    = 8'hFF;
  localparam logic [7:0] ALL_DARK     = 8'h00;

  localparam logic ADDR_THRESH = 1'b0;

  // reciprocal scale: q = (n * recip) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 10;

  typedef struct packed {
    logic              black;
    logic              start;
    logic signed [3:0] weight;
  } lane_t;

  typedef struct packed {
    logic [7:0]        bits;
    logic [3:0]        count;
    logic [3:0]        starts;
    logic signed [5:0] wsum;
  } summary_t;

  typedef struct packed {
    logic [7:0]        raw;
    logic [3:0]        total;
    logic signed [6:0] pos;
    logic [2:0]        status;
  } result_t;

  typedef struct packed {
    logic              pos_upd;
    logic signed [7:0] pos;
    logic              dir_upd;
    logic [1:0]        dir;
  } track_upd_t;

  // channel weight in half units: 2*i - 7
  function automatic logic signed [3:0] lane_weight(input int idx);
    lane_weight = 4'(2 * idx - 7);
  endfunction

  // ceil(1024 / c); exact truncation for numerators up to 128
  function automatic logic [10:0] recip(input logic [2:0] c);
    case (c)
      3'd1: recip = 11'd1024;
      3'd2: recip = 11'd512;
      3'd3: recip = 11'd342;
      3'd4: recip = 11'd256;
      3'd5: recip = 11'd205;
      3'd6: recip = 11'd171;
      3'd7: recip = 11'd147;
      default: recip = 11'd0;
    endcase
  endfunction

endpackage

// ----- rtl/core/lsp_lane.sv -----
module lsp_lane
  import lsp_pkg::*;
(
  input  logic              bit_in,
  input  logic              prev_in,
  input  logic signed [3:0] weight,
  output lane_t             lane
);

  // a run of black starts where the lower neighbor is white
  assign lane.black  = ~bit_in;
  assign lane.start  = ~bit_in & prev_in;
  assign lane.weight = bit_in ? 4'sd0 : weight;

endmodule

// ----- rtl/core/lsp_merge.sv -----
module lsp_merge
  import lsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  load,
  input  logic [NUM_CH-1:0]     bits,
  input  lane_t [NUM_CH-1:0]    lanes,
  output summary_t              summary
);

  summary_t summary_next;

  always_comb begin
    summary_next.bits   = bits;
    summary_next.count  = '0;
    summary_next.starts = '0;
    summary_next.wsum   = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      summary_next.count  = summary_next.count + 4'(lanes[i].black);
      summary_next.starts = summary_next.starts + 4'(lanes[i].start);
      summary_next.wsum   = summary_next.wsum + 6'(lanes[i].weight);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      summary <= summary_next;
    end
  end

endmodule

// ----- rtl/core/lsp_classify.sv -----
module lsp_classify
  import lsp_pkg::*;
(
  input  summary_t          summary,
  input  logic [3:0]        thresh,
  input  logic signed [7:0] last_position,
  input  logic [1:0]        last_direction,
  output result_t           result,
  output track_upd_t        upd
);

  logic              neg;
  logic [4:0]        mag;
  logic [7:0]        numer;
  logic [18:0]       prod;
  logic [6:0]        quot;
  logic signed [6:0] pos;

  always_comb begin
    neg   = summary.wsum < 0;
    mag   = neg ? 5'(-summary.wsum) : 5'(summary.wsum);
    numer = {mag, 3'b000};
    prod  = 19'(numer) * 19'(recip(summary.count[2:0]));
    quot  = prod[RECIP_SHIFT+6:RECIP_SHIFT];
    pos   = neg ? -$signed(quot) : $signed(quot);

    result.raw    = summary.bits;
    result.total  = summary.count;
    result.pos    = '0;
    result.status = ST_OK;
    upd.pos_upd   = 1'b0;
    upd.pos       = 8'(pos);
    upd.dir_upd   = 1'b0;
    upd.dir       = neg ? DIR_LEFT : DIR_RIGHT;

    if (summary.bits == ALL_WHITE) begin
      result.total = '0;
      result.pos   = last_position[6:0];
      case (last_direction)
        DIR_LEFT:  result.status = ST_LOST_LEFT;
        DIR_RIGHT: result.status = ST_LOST_RIGHT;
        default:   result.status = ST_LOST_UNKNOWN;
      endcase
    end else if (summary.bits == ALL_DARK) begin
      result.status = ST_ALL_BLACK;
    end else if (summary.starts != 4'd1) begin
      result.status = ST_DISCONT;
    end else if (summary.count >= thresh) begin
      result.status = ST_ALL_BLACK;
    end else begin
      result.pos  = pos;
      upd.pos_upd = 1'b1;
      // a centered line keeps the remembered direction
      upd.dir_upd = (pos != 7'sd0);
    end
  end

endmodule

// ----- rtl/core/line_sensor_position_estimator.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_ready    sensor_bits
// output    out_valid / out_ready  raw_echo, black_total, line_position, track_status
// config    APB psel/penable       paddr, pwdata, prdata (max_black_threshold at 0x0)
//
// An item moves through registers in turn: the sample is registered at acceptance, the
// eight lane results are merged into the summary register, then the division by the black
// count and the classification fill the output register. One item is in flight at a time;
// the next is taken when classification has moved its result out, even if out_ready is low,
// so one result waits in the output register. A held output stalls the classify stage until
// taken. Reset is synchronous and clears the valid flags, the remembered position and
// direction, and sets the threshold to 6.
module line_sensor_position_estimator
  import lsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        sensor_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        raw_echo,
  output logic [3:0]        black_total,
  output logic signed [6:0] line_position,
  output logic [2:0]        track_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic                  sample_valid;
  logic [NUM_CH-1:0]     sample;
  logic                  merged_valid;
  logic [3:0]            thresh;
  logic signed [7:0]     last_position;
  logic [1:0]            last_direction;
  lane_t [NUM_CH-1:0]    lanes;
  summary_t              summary;
  result_t               result;
  track_upd_t            upd;
  logic                  advance;

  assign pready   = 1'b1;
  assign in_ready = ~sample_valid & ~merged_valid;
  assign advance  = merged_valid & (~out_valid | out_ready);
  assign prdata   = (paddr[2] == ADDR_THRESH) ? {28'd0, thresh} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_THRESH) begin
      thresh <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      merged_valid <= 1'b0;
    end else begin
      sample_valid <= in_valid & in_ready;
      if (sample_valid) begin
        merged_valid <= 1'b1;
      end else if (advance) begin
        merged_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= sensor_bits;
    end
  end

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    lsp_lane u_lane (
      .bit_in  (sample[i]),
      .prev_in ((i == 0) ? 1'b1 : sample[(i == 0) ? 0 : i - 1]),
      .weight  (lane_weight(i)),
      .lane    (lanes[i])
    );
  end

  lsp_merge u_merge (
    .clk     (clk),
    .load    (sample_valid),
    .bits    (sample),
    .lanes   (lanes),
    .summary (summary)
  );

  lsp_classify u_classify (
    .summary        (summary),
    .thresh         (thresh),
    .last_position  (last_position),
    .last_direction (last_direction),
    .result         (result),
    .upd            (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position  <= '0;
      last_direction <= DIR_UNKNOWN;
    end else if (advance) begin
      if (upd.pos_upd) begin
        last_position <= upd.pos;
      end
      if (upd.dir_upd) begin
        last_direction <= upd.dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw_echo      <= result.raw;
      black_total   <= result.total;
      line_position <= result.pos;
      track_status  <= result.status;
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_stage_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sample_valid && merged_valid))
    else $error("sample and merge stages both hold an item");

  a_lost_zero_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && (track_status == ST_LOST_LEFT || track_status == ST_LOST_RIGHT ||
                  track_status == ST_LOST_UNKNOWN) |-> black_total == 4'd0)
    else $error("lost status with nonzero black count");

  a_ok_position: assert property (@(posedge clk) disable iff (rst)
    advance && upd.pos_upd |-> result.status == ST_OK && result.total != 4'd0)
    else $error("position update without an ok result");
`endif

endmodule

// ----- test/line_sensor_position_estimator_checker.sv -----
`timescale 1ns / 1ps

module line_sensor_position_estimator_checker
  import lsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        sensor_bits,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        raw_echo,
  input  logic [3:0]        black_total,
  input  logic signed [6:0] line_position,
  input  logic [2:0]        track_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                errors,
  output int                pending
);

  result_t           track_q [$];
  logic [3:0]        thresh   = THRESH_RESET;
  logic signed [7:0] last_pos = '0;
  logic [1:0]        last_dir = DIR_UNKNOWN;
  int                err_cnt  = 0;

  function automatic void flag(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endfunction

  // classify one sample and advance the remembered position and direction
  function automatic result_t track_sample(input logic [7:0] s);
    result_t r;
    int cnt;
    int first;
    int last;
    int wsum;
    int pos;
    cnt = 0;
    first = 0;
    last = 0;
    wsum = 0;
    r.raw = s;
    r.total = 4'd0;
    r.pos = '0;
    if (s == ALL_WHITE) begin
      r.pos = last_pos[6:0];
      case (last_dir)
        DIR_LEFT:  r.status = ST_LOST_LEFT;
        DIR_RIGHT: r.status = ST_LOST_RIGHT;
        default:   r.status = ST_LOST_UNKNOWN;
      endcase
      return r;
    end
    if (s == ALL_DARK) begin
      r.total = 4'(NUM_CH);
      r.status = ST_ALL_BLACK;
      return r;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      if (!s[i]) begin
        if (cnt == 0) first = i;
        last = i;
        cnt++;
        wsum += 2 * i - 7;
      end
    end
    r.total = 4'(cnt);
    if (last - first + 1 != cnt) begin
      r.status = ST_DISCONT;
    end else if (cnt >= int'(thresh)) begin
      r.status = ST_ALL_BLACK;
    end else begin
      // int division truncates toward zero
      pos = (wsum * 8) / cnt;
      r.pos = 7'(pos);
      r.status = ST_OK;
      last_pos = 8'(pos);
      if (pos < 0) last_dir = DIR_LEFT;
      else if (pos > 0) last_dir = DIR_RIGHT;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      thresh = THRESH_RESET;
      last_pos = '0;
      last_dir = DIR_UNKNOWN;
      track_q.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == ADDR_THRESH) begin
        if (pwrite) begin
          thresh = pwdata[3:0];
        end else if (prdata[3:0] != thresh) begin
          flag($sformatf("threshold read exp %0d got %0d", thresh, prdata[3:0]));
        end
      end
      if (in_valid && in_ready) begin
        track_q.push_back(track_sample(sensor_bits));
      end
      if (out_valid && out_ready) begin
        got = {raw_echo, black_total, line_position, track_status};
        if (track_q.size() == 0) begin
          flag($sformatf("unexpected item raw=%h total=%0d pos=%0d status=%0d",
                         got.raw, got.total, got.pos, got.status));
        end else begin
          want = track_q.pop_front();
          if (got != want) begin
            flag($sformatf({"raw=%h exp (total=%0d pos=%0d status=%0d)",
                            " got (raw=%h total=%0d pos=%0d status=%0d)"},
                           want.raw, want.total, want.pos, want.status,
                           got.raw, got.total, got.pos, got.status));
          end
        end
      end
    end
    errors <= err_cnt;
    pending <= track_q.size();
  end

endmodule

// ----- test/line_sensor_position_estimator_tb.sv -----
`timescale 1ns / 1ps

module line_sensor_position_estimator_tb
  import lsp_pkg::*;
();

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [7:0]        sensor_bits = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [7:0]        raw_echo;
  logic [3:0]        black_total;
  logic signed [6:0] line_position;
  logic [2:0]        track_status;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [2:0]        paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                errors;
  int                pending;

  logic              idling      = 1'b1;
  int unsigned       stall_left  = 0;

  localparam logic [2:0] THRESH_ADDR = {ADDR_THRESH, 2'b00};
  localparam logic [2:0] SPARE_ADDR  = {~ADDR_THRESH, 2'b00};
  localparam int         PHASE_ITEMS = 135;

  // lost with no direction, lost after each side, centered zero, gaps, long runs
  logic [7:0] opening [$] = '{8'hFF, 8'h00, 8'hFE, 8'hFF, 8'h7F, 8'hFF, 8'hE7, 8'hFF,
                              8'h7E, 8'hAA, 8'h55, 8'hC0, 8'h81, 8'hE0, 8'h80, 8'h01,
                              8'h07, 8'hFC, 8'h3F, 8'hFF};

  logic [3:0] phase_thresh [6];

  line_sensor_position_estimator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sensor_bits(sensor_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .raw_echo(raw_echo), .black_total(black_total),
    .line_position(line_position), .track_status(track_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  line_sensor_position_estimator_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sensor_bits(sensor_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .raw_echo(raw_echo), .black_total(black_total),
    .line_position(line_position), .track_status(track_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  // stall the result side in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] line_sample();
    int len;
    int at;
    case ($urandom_range(0, 9))
      0: return ALL_WHITE;
      1: return ALL_DARK;
      2, 3: return 8'($urandom);
      default: begin
        len = $urandom_range(1, 7);
        at = $urandom_range(0, NUM_CH - len);
        return ~(8'((1 << len) - 1) << at);
      end
    endcase
  endfunction

  task automatic send_sample(input logic [7:0] s);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_bits <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain the block, then write and read back
  task automatic set_threshold(input logic [2:0] addr, input logic [3:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    apb_access(1'b1, addr, {28'($urandom), val});
    apb_access(1'b0, THRESH_ADDR, '0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[k]) send_sample(opening[k]);

    set_threshold(THRESH_ADDR, 4'd1);
    send_sample(8'hFE);
    send_sample(8'hE7);
    send_sample(8'hFF);
    set_threshold(THRESH_ADDR, 4'd8);
    send_sample(8'h80);
    send_sample(8'h01);
    send_sample(8'hFF);
    // unmapped register: threshold must stay at 8
    set_threshold(SPARE_ADDR, 4'd0);
    send_sample(8'h80);
    set_threshold(THRESH_ADDR, 4'd0);
    send_sample(8'hFE);
    send_sample(8'hF0);
    set_threshold(THRESH_ADDR, 4'd15);
    send_sample(8'h80);

    phase_thresh = '{4'($urandom_range(1, 8)), 4'd0, 4'd15, 4'd8, 4'd1, THRESH_RESET};
    foreach (phase_thresh[ph]) begin
      idling = (ph != 2 && ph != 5);
      set_threshold(THRESH_ADDR, phase_thresh[ph]);
      repeat (PHASE_ITEMS) send_sample(line_sample());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
